### rtl/core/hms_pkg.sv
// Package with the types, constants and digit split shared by the timer modules.
`timescale 1ns / 1ps
`default_nettype none

package hms_pkg;

  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_TICK   = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_PAUSE  = 3'd3;
  localparam logic [2:0] OP_RESUME = 3'd4;

  localparam logic [4:0] TOP_HOUR   = 5'd23;
  localparam logic [5:0] TOP_MINSEC = 6'd59;
  localparam logic [3:0] RADIX      = 4'd10;
  // Multiply by 13 and shift right by 7 gives the tens digit for every value below 64.
  localparam logic [3:0] RECIP_10   = 4'd13;

  localparam int BTN_HR_UP   = 0;
  localparam int BTN_HR_DN   = 1;
  localparam int BTN_MIN_UP  = 2;
  localparam int BTN_MIN_DN  = 3;
  localparam int BTN_SEC_UP  = 4;
  localparam int BTN_SEC_DN  = 5;
  localparam int BTN_MODE    = 6;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hr;
    logic       down;
    logic       run;
    logic       alarm;
    logic [6:0] prev;
  } hms_state_t;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [2:0] second_tens;
    logic [3:0] second_ones;
    logic       counting_down;
    logic       alarm;
    logic       is_running;
  } hms_result_t;

  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [9:0] p;
    p = {4'b0000, v} * {6'b000000, RECIP_10};
    return p[9:7];
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v, input logic [2:0] t);
    logic [5:0] tp;
    logic [5:0] d;
    tp = {3'b000, t} * {2'b00, RADIX};
    d  = v - tp;
    return d[3:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/hms_if.sv
// Valid/ready channel interfaces for the timer samples and results.
`timescale 1ns / 1ps
`default_nettype none

interface hms_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [6:0] buttons_n;

  modport source (output valid, output opcode, output buttons_n, input ready);
  modport sink (input valid, input opcode, input buttons_n, output ready);
endinterface

interface hms_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] hour_tens;
  logic [3:0] hour_ones;
  logic [2:0] minute_tens;
  logic [3:0] minute_ones;
  logic [2:0] second_tens;
  logic [3:0] second_ones;
  logic       counting_down;
  logic       alarm;
  logic       is_running;

  modport source (output valid, output hour_tens, output hour_ones, output minute_tens,
                  output minute_ones, output second_tens, output second_ones,
                  output counting_down, output alarm, output is_running, input ready);
  modport sink (input valid, input hour_tens, input hour_ones, input minute_tens,
                input minute_ones, input second_tens, input second_ones,
                input counting_down, input alarm, input is_running, output ready);
endinterface

`default_nettype wire

### rtl/core/hms_step.sv
// Next-state logic of the timer for one sample: events, mode toggle, tick and set buttons.
`timescale 1ns / 1ps
`default_nettype none

module hms_step
  import hms_pkg::*;
(
  input  wire hms_state_t st,
  input  wire logic [2:0] opcode,
  input  wire logic [6:0] buttons_n,
  output hms_state_t      st_nxt,
  output logic            counting_down
);

  logic [6:0] pressed;
  logic [6:0] edges;
  logic       mode_held;
  hms_state_t s;

  always_comb begin
    pressed   = ~buttons_n;
    edges     = pressed & st.prev;
    mode_held = pressed[BTN_MODE];
    s         = st;

    unique case (opcode)
      OP_CLEAR: begin
        s.sec   = '0;
        s.min   = '0;
        s.hr    = '0;
        s.alarm = 1'b0;
      end
      OP_PAUSE:  s.run = 1'b0;
      OP_RESUME: s.run = 1'b1;
      default: ;
    endcase

    if (edges[BTN_MODE] && !s.run) begin
      s.down = !s.down;
    end

    if (opcode == OP_TICK && s.run) begin
      if (mode_held || s.down) begin
        if (s.hr == '0 && s.min == '0 && s.sec == '0) begin
          s.alarm = 1'b1;
        end else if (s.sec != '0) begin
          s.sec = s.sec - 6'd1;
        end else begin
          s.sec = TOP_MINSEC;
          if (s.min != '0) begin
            s.min = s.min - 6'd1;
          end else begin
            s.min = TOP_MINSEC;
            s.hr  = s.hr - 5'd1;
          end
        end
      end else begin
        if (s.sec < TOP_MINSEC) begin
          s.sec = s.sec + 6'd1;
        end else begin
          s.sec = '0;
          if (s.min < TOP_MINSEC) begin
            s.min = s.min + 6'd1;
          end else begin
            s.min = '0;
            s.hr  = (s.hr < TOP_HOUR) ? s.hr + 5'd1 : 5'd0;
          end
        end
      end
    end

    if (edges[BTN_HR_UP])  s.hr  = (s.hr < TOP_HOUR) ? s.hr + 5'd1 : 5'd0;
    if (edges[BTN_HR_DN])  s.hr  = (s.hr != '0) ? s.hr - 5'd1 : 5'd0;
    if (edges[BTN_MIN_UP]) s.min = (s.min < TOP_MINSEC) ? s.min + 6'd1 : 6'd0;
    if (edges[BTN_MIN_DN]) s.min = (s.min != '0) ? s.min - 6'd1 : 6'd0;
    if (edges[BTN_SEC_UP]) s.sec = (s.sec < TOP_MINSEC) ? s.sec + 6'd1 : 6'd0;
    if (edges[BTN_SEC_DN]) s.sec = (s.sec != '0) ? s.sec - 6'd1 : 6'd0;

    s.prev        = buttons_n;
    st_nxt        = s;
    counting_down = s.down || mode_held;
  end

endmodule

`default_nettype wire

### rtl/core/hms_digits.sv
// Splits the updated time into decimal digits and forms the result request.
`timescale 1ns / 1ps
`default_nettype none

module hms_digits
  import hms_pkg::*;
(
  input  wire hms_state_t st,
  input  wire logic       counting_down,
  output hms_result_t     res
);

  logic [5:0] hr_ext;
  logic [2:0] hr_t;
  logic [2:0] min_t;
  logic [2:0] sec_t;

  always_comb begin
    hr_ext = {1'b0, st.hr};
    hr_t   = tens_of(hr_ext);
    min_t  = tens_of(st.min);
    sec_t  = tens_of(st.sec);

    res.hour_tens     = hr_t[1:0];
    res.hour_ones     = ones_of(hr_ext, hr_t);
    res.minute_tens   = min_t;
    res.minute_ones   = ones_of(st.min, min_t);
    res.second_tens   = sec_t;
    res.second_ones   = ones_of(st.sec, sec_t);
    res.counting_down = counting_down;
    res.alarm         = st.alarm;
    res.is_running    = st.run;
  end

endmodule

`default_nettype wire

### rtl/core/up_down_hms_timer.sv
// Up/down hours:minutes:seconds timer with registered sample input and result output.
// Each input request carries an event opcode (none, tick, clear, pause, resume) and the
// seven active-low button levels; each one produces exactly one result request with the
// six time digits and the down, alarm and running status bits after the update.
// A sample is captured in an input register; once the result register is empty or being taken,
// the time update and digit split are worked out and written to the result register with the state.
// The result passes through the input register and then the result register, and one sample
// can be taken in every cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its request and the input register
// holds the pending sample; in_chan.ready stays high while the input register is empty or
// moves on in the same cycle, so a third sample waits until the result is taken.
// Synchronous active-low reset empties both registers, zeroes the time, clears the down
// and alarm flags, sets the timer running and marks all buttons as released.
`timescale 1ns / 1ps
`default_nettype none

module up_down_hms_timer
  import hms_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  hms_in_if.sink     in_chan,
  hms_out_if.source  out_chan
);

  logic        in_valid_r;
  logic [2:0]  opcode_r;
  logic [6:0]  buttons_n_r;
  logic        out_valid_r;
  hms_result_t res_r;
  hms_result_t res_nxt;
  hms_state_t  st_r;
  hms_state_t  st_nxt;
  logic        cnt_down;
  logic        advance;

  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  hms_step u_step (
    .st            (st_r),
    .opcode        (opcode_r),
    .buttons_n     (buttons_n_r),
    .st_nxt        (st_nxt),
    .counting_down (cnt_down)
  );

  hms_digits u_digits (
    .st            (st_nxt),
    .counting_down (cnt_down),
    .res           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r.sec    <= '0;
      st_r.min    <= '0;
      st_r.hr     <= '0;
      st_r.down   <= 1'b0;
      st_r.run    <= 1'b1;
      st_r.alarm  <= 1'b0;
      st_r.prev   <= '1;
    end else begin
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (advance) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      opcode_r    <= in_chan.opcode;
      buttons_n_r <= in_chan.buttons_n;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.hour_tens     = res_r.hour_tens;
  assign out_chan.hour_ones     = res_r.hour_ones;
  assign out_chan.minute_tens   = res_r.minute_tens;
  assign out_chan.minute_ones   = res_r.minute_ones;
  assign out_chan.second_tens   = res_r.second_tens;
  assign out_chan.second_ones   = res_r.second_ones;
  assign out_chan.counting_down = res_r.counting_down;
  assign out_chan.alarm         = res_r.alarm;
  assign out_chan.is_running    = res_r.is_running;

`ifndef NO_ASSERTIONS
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (st_r.run && !in_valid_r && !out_valid_r))
    else $error("reset did not leave the timer running and empty");

  a_hold_state: assert property (@(posedge clk)
    (rst_n && !advance) |=> $stable(st_r))
    else $error("timer state changed without a sample moving on");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.hr <= TOP_HOUR && st_r.min <= TOP_MINSEC && st_r.sec <= TOP_MINSEC))
    else $error("time value out of range");
`endif

endmodule

`default_nettype wire

### tb/tb_up_down_hms_timer.sv
// Self-checking testbench for the up/down hours:minutes:seconds timer.
`timescale 1ns / 1ps

module tb_up_down_hms_timer;
  import hms_pkg::*;

  localparam logic [6:0] ALL_RELEASED = 7'h7F;
  localparam logic [6:0] M_HR_UP  = 7'(1 << BTN_HR_UP);
  localparam logic [6:0] M_HR_DN  = 7'(1 << BTN_HR_DN);
  localparam logic [6:0] M_MIN_UP = 7'(1 << BTN_MIN_UP);
  localparam logic [6:0] M_MIN_DN = 7'(1 << BTN_MIN_DN);
  localparam logic [6:0] M_SEC_UP = 7'(1 << BTN_SEC_UP);
  localparam logic [6:0] M_SEC_DN = 7'(1 << BTN_SEC_DN);
  localparam logic [6:0] M_MODE   = 7'(1 << BTN_MODE);
  localparam int NUM_SAMPLES = 1850;
  localparam int LONG_HOLD = 150;

  typedef struct {
    bit         wait_empty;
    logic [2:0] op;
    logic [6:0] btn_n;
  } sample_t;

  logic clk;
  logic rst_n;

  hms_in_if  in_if ();
  hms_out_if out_if ();

  up_down_hms_timer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  sample_t     sample_q[$];
  hms_result_t expected_q[$];
  bit          gate_next = 1'b0;
  bit          sample_taken = 1'b0;
  int          n_accepted = 0;
  int          n_results = 0;
  int          n_errors = 0;
  int          n_ticks = 0;
  int          n_paused_ticks = 0;
  int          n_day_wraps = 0;
  int          n_alarm_results = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  logic [5:0] cur_sec = '0;
  logic [5:0] cur_min = '0;
  logic [4:0] cur_hr = '0;
  logic       down_mode = 1'b0;
  logic       running = 1'b1;
  logic       alarm_on = 1'b0;
  logic [6:0] last_btn_n = ALL_RELEASED;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  function automatic hms_result_t advance_timer(input logic [2:0] op, input logic [6:0] btn_n);
    logic [6:0]  pressed;
    logic [6:0]  press_edges;
    logic        mode_held;
    hms_result_t r;
    pressed = ~btn_n;
    press_edges = pressed & last_btn_n;
    mode_held = pressed[BTN_MODE];
    case (op)
      OP_CLEAR: begin
        cur_sec = '0;
        cur_min = '0;
        cur_hr = '0;
        alarm_on = 1'b0;
      end
      OP_PAUSE: running = 1'b0;
      OP_RESUME: running = 1'b1;
      default: ;
    endcase
    if (press_edges[BTN_MODE] && !running) down_mode = !down_mode;
    if (op == OP_TICK && !running) n_paused_ticks++;
    if (op == OP_TICK && running) begin
      n_ticks++;
      if (mode_held || down_mode) begin
        if (cur_hr == 0 && cur_min == 0 && cur_sec == 0) begin
          alarm_on = 1'b1;
        end else if (cur_sec != 0) begin
          cur_sec = cur_sec - 6'd1;
        end else begin
          cur_sec = TOP_MINSEC;
          if (cur_min != 0) begin
            cur_min = cur_min - 6'd1;
          end else begin
            cur_min = TOP_MINSEC;
            if (cur_hr != 0) cur_hr = cur_hr - 5'd1;
          end
        end
      end else if (cur_sec < TOP_MINSEC) begin
        cur_sec = cur_sec + 6'd1;
      end else begin
        cur_sec = '0;
        if (cur_min < TOP_MINSEC) begin
          cur_min = cur_min + 6'd1;
        end else begin
          cur_min = '0;
          if (cur_hr < TOP_HOUR) begin
            cur_hr = cur_hr + 5'd1;
          end else begin
            cur_hr = '0;
            n_day_wraps++;
          end
        end
      end
    end
    if (press_edges[BTN_HR_UP]) cur_hr = (cur_hr < TOP_HOUR) ? cur_hr + 5'd1 : 5'd0;
    if (press_edges[BTN_HR_DN] && cur_hr != 0) cur_hr = cur_hr - 5'd1;
    if (press_edges[BTN_MIN_UP]) cur_min = (cur_min < TOP_MINSEC) ? cur_min + 6'd1 : 6'd0;
    if (press_edges[BTN_MIN_DN] && cur_min != 0) cur_min = cur_min - 6'd1;
    if (press_edges[BTN_SEC_UP]) cur_sec = (cur_sec < TOP_MINSEC) ? cur_sec + 6'd1 : 6'd0;
    if (press_edges[BTN_SEC_DN] && cur_sec != 0) cur_sec = cur_sec - 6'd1;
    last_btn_n = btn_n;
    if (alarm_on) n_alarm_results++;
    r.hour_tens = 2'(cur_hr / 10);
    r.hour_ones = 4'(cur_hr % 10);
    r.minute_tens = 3'(cur_min / 10);
    r.minute_ones = 4'(cur_min % 10);
    r.second_tens = 3'(cur_sec / 10);
    r.second_ones = 4'(cur_sec % 10);
    r.counting_down = down_mode | mode_held;
    r.alarm = alarm_on;
    r.is_running = running;
    return r;
  endfunction

  function automatic bit quiet_stretch();
    return n_accepted >= 700 && n_accepted < 1100;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                n_results, name, got, want));
  endtask

  // Results are checked before new requests are predicted, so a stray result is never
  // matched against a sample taken in the same cycle.
  always @(posedge clk) begin : monitor
    hms_result_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", n_results));
        end else begin
          want = expected_q.pop_front();
          check_field("hour_tens", out_if.hour_tens, want.hour_tens);
          check_field("hour_ones", out_if.hour_ones, want.hour_ones);
          check_field("minute_tens", out_if.minute_tens, want.minute_tens);
          check_field("minute_ones", out_if.minute_ones, want.minute_ones);
          check_field("second_tens", out_if.second_tens, want.second_tens);
          check_field("second_ones", out_if.second_ones, want.second_ones);
          check_field("counting_down", out_if.counting_down, want.counting_down);
          check_field("alarm", out_if.alarm, want.alarm);
          check_field("is_running", out_if.is_running, want.is_running);
        end
      end
      if (in_if.valid && in_if.ready) begin
        expected_q.push_back(advance_timer(in_if.opcode, in_if.buttons_n));
        n_accepted++;
        sample_taken = 1'b1;
      end
    end
  end

  always @(negedge clk) begin : driver
    sample_t nxt;
    if (rst_n && (!in_if.valid || sample_taken)) begin
      sample_taken = 1'b0;
      if (sample_q.size() != 0 && !(sample_q[0].wait_empty && expected_q.size() != 0) &&
          (quiet_stretch() || $urandom_range(99) >= 8)) begin
        nxt = sample_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.opcode <= nxt.op;
        in_if.buttons_n <= nxt.btn_n;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= 500) begin
      out_if.ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_if.ready <= quiet_stretch() || $urandom_range(99) >= 8;
    end
  end

  task automatic add_sample(input logic [2:0] op, input logic [6:0] btn_n);
    sample_t s;
    s.wait_empty = gate_next;
    s.op = op;
    s.btn_n = btn_n;
    gate_next = 1'b0;
    sample_q.push_back(s);
  endtask

  task automatic press_release(input logic [6:0] mask);
    add_sample(OP_NONE, ~mask);
    add_sample(OP_NONE, ALL_RELEASED);
  endtask

  task automatic add_run(input int len);
    int r;
    logic [2:0] op;
    logic [6:0] btn_n;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 70) op = OP_TICK;
      else if (r < 76) op = OP_NONE;
      else if (r < 84) op = OP_PAUSE;
      else if (r < 94) op = OP_RESUME;
      else if (r < 96) op = OP_CLEAR;
      else op = 3'($urandom_range(7, 5));
      r = $urandom_range(99);
      if (r < 80) btn_n = ALL_RELEASED;
      else if (r < 88) btn_n = ~M_MODE;
      else btn_n = ~7'(1 << $urandom_range(6));
      add_sample(op, btn_n);
    end
  endtask

  function automatic int pick_minsec();
    case ($urandom_range(5))
      0: return 0;
      1: return 1;
      2: return 58;
      3: return 59;
      default: return $urandom_range(59);
    endcase
  endfunction

  initial begin : stimulus
    int hr_steps;
    int min_steps;
    int sec_steps;
    int steps;
    int m;
    int s;
    bit borrow;
    logic [6:0] mask;

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_NONE;
    in_if.buttons_n = ALL_RELEASED;
    out_if.ready = 1'b0;

    // Directed opening: saturation, carries, alarm, pause, mode toggling and unused codes.
    add_sample(OP_NONE, ALL_RELEASED);
    add_sample(OP_TICK, ALL_RELEASED);
    add_sample(OP_NONE, ~M_SEC_DN);
    add_sample(OP_NONE, ~M_SEC_DN);
    add_sample(OP_NONE, ALL_RELEASED);
    add_sample(OP_NONE, ~(M_HR_DN | M_MIN_DN | M_SEC_DN));
    add_sample(OP_NONE, ~M_MIN_UP);
    add_sample(OP_TICK, ~M_MODE);
    add_sample(OP_NONE, ~(M_MODE | M_SEC_UP));
    add_sample(OP_TICK, ~M_MODE);
    add_sample(OP_CLEAR, ALL_RELEASED);
    add_sample(OP_TICK, ALL_RELEASED);
    add_sample(OP_PAUSE, ALL_RELEASED);
    add_sample(OP_TICK, ALL_RELEASED);
    add_sample(OP_NONE, ~(M_MODE | M_HR_UP | M_MIN_UP));
    add_sample(OP_TICK, ALL_RELEASED);
    add_sample(OP_RESUME, ALL_RELEASED);
    add_sample(OP_TICK, ALL_RELEASED);
    add_sample(3'd5, ALL_RELEASED);
    add_sample(3'd6, 7'h00);
    add_sample(3'd7, ALL_RELEASED);
    add_sample(OP_TICK, ~M_HR_DN);
    add_sample(OP_PAUSE, ~M_MODE);
    add_sample(OP_RESUME, ALL_RELEASED);
    add_sample(OP_TICK, ALL_RELEASED);
    gate_next = 1'b1;

    while (sample_q.size() < NUM_SAMPLES) begin
      if ($urandom_range(14) == 0) gate_next = 1'b1;
      case ($urandom_range(9))
        0, 1: begin
          repeat ($urandom_range(20, 5)) add_sample(3'($urandom_range(7)), 7'($urandom_range(127)));
        end
        2, 3, 4, 5: begin
          // Preset a time with set-button requests, then let it count.
          steps = ($urandom_range(3) == 0) ? 23 : $urandom_range(23);
          m = pick_minsec();
          s = pick_minsec();
          borrow = (m >= 30 || s >= 30);
          add_sample(OP_CLEAR, ALL_RELEASED);
          add_sample(OP_RESUME, ALL_RELEASED);
          if (borrow) begin
            // One hour counted down by a single tick leaves 00:59:59.
            press_release(M_HR_UP);
            add_sample(OP_TICK, ~M_MODE);
            add_sample(OP_NONE, ALL_RELEASED);
          end
          hr_steps = steps;
          min_steps = borrow ? 59 - m : m;
          sec_steps = borrow ? 59 - s : s;
          steps = hr_steps;
          if (min_steps > steps) steps = min_steps;
          if (sec_steps > steps) steps = sec_steps;
          for (int i = 0; i < steps; i++) begin
            mask = '0;
            if (i < hr_steps) mask |= M_HR_UP;
            if (i < min_steps) mask |= borrow ? M_MIN_DN : M_MIN_UP;
            if (i < sec_steps) mask |= borrow ? M_SEC_DN : M_SEC_UP;
            press_release(mask);
          end
          if ($urandom_range(1) == 0) begin
            add_sample(OP_PAUSE, ALL_RELEASED);
            add_sample(OP_NONE, ~M_MODE);
            add_sample(OP_RESUME, ALL_RELEASED);
          end
          add_run($urandom_range(60, 20));
        end
        default: add_run($urandom_range(50, 10));
      endcase
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (sample_q.size() != 0 || in_if.valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d samples: %0d counted ticks, %0d ticks while paused.",
             n_accepted, n_ticks, n_paused_ticks);
    $display("Checked %0d results; %0d day wraps, %0d results with the alarm set.",
             n_results, n_day_wraps, n_alarm_results);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### up_down_hms_timer.f
rtl/core/hms_pkg.sv
rtl/core/hms_if.sv
rtl/core/hms_step.sv
rtl/core/hms_digits.sv
rtl/core/up_down_hms_timer.sv
tb/tb_up_down_hms_timer.sv
